>>> rtl/token_classifier_unit_defines.svh
// assertion macros shared by the token classifier rtl
`ifndef TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// checked on every clock edge outside reset
`define TCLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define TCLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/tcls_pkg.sv
// shared types, character codes and classification functions of the token classifier
package tcls_pkg;

  typedef enum logic [2:0] {
    CLS_DIVIDER  = 3'd0,
    CLS_OPERATOR = 3'd1,
    CLS_KEYWORD  = 3'd2,
    CLS_INTEGER  = 3'd3,
    CLS_REAL     = 3'd4,
    CLS_IDENT    = 3'd5,
    CLS_INVALID  = 3'd6
  } token_class_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned KW_BEGIN_LEN = 5;
  localparam int unsigned KW_END_LEN   = 3;

  typedef struct packed {
    token_class_e cls;
    logic [15:0]  start;
    logic [7:0]   length;
    logic [7:0]   delim;
    logic         last;
  } token_t;

  typedef struct packed {
    logic [1:0] cnt;
    token_t     first;
    token_t     second;
  } token_pair_t;

  typedef struct packed {
    logic all_digits;
    logic digits_or_dots;
    logic seen_dot;
    logic first_is_digit;
    logic begin_match;
    logic end_match;
  } word_flags_t;

  localparam word_flags_t FLAGS_CLEAR = '{
    all_digits: 1'b1, digits_or_dots: 1'b1, seen_dot: 1'b0,
    first_is_digit: 1'b0, begin_match: 1'b1, end_match: 1'b1
  };

  function automatic logic is_divider(logic [7:0] c);
    return (c == CH_SEMI) || (c == CH_EQ) || (c == CH_LPAR) || (c == CH_RPAR);
  endfunction

  function automatic logic is_operator(logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_COMMA) || is_divider(c) || is_operator(c);
  endfunction

  function automatic logic [7:0] kw_begin_char(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h62;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h67;
      3'd3:    r = 8'h69;
      3'd4:    r = 8'h6e;
      default: r = 8'h62;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_end_char(logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0:    r = 8'h65;
      2'd1:    r = 8'h6e;
      2'd2:    r = 8'h64;
      default: r = 8'h65;
    endcase
    return r;
  endfunction

  function automatic token_class_e word_class(word_flags_t f, logic len_is5, logic len_is3);
    token_class_e r;
    if ((f.begin_match && len_is5) || (f.end_match && len_is3)) begin
      r = CLS_KEYWORD;
    end else if (f.all_digits) begin
      r = CLS_INTEGER;
    end else if (f.digits_or_dots && f.seen_dot) begin
      r = CLS_REAL;
    end else if (f.first_is_digit) begin
      r = CLS_INVALID;
    end else begin
      r = CLS_IDENT;
    end
    return r;
  endfunction

endpackage

>>> rtl/token_classifier_unit.sv
// top level of the token classifier: character stream in, token beats out
// Takes one text byte per beat and reports words (keyword, integer, real, identifier,
// invalid word) and the dividers and operators that end them. A character is accepted
// every cycle while the four-entry result queue has at least two free slots; the tokens of
// a character are registered in the result queue. A character that closes a word and is
// itself a divider or operator yields two output beats, so sustained input rate is one
// character per cycle when each character yields at most one token and output is ready;
// otherwise it is set by the single output port that drains the queue one token per cycle
// while it is ready. tlast on the input marks the final character of a text and flushes
// the open word; tlast on the output marks the final token caused by one input character.
`include "token_classifier_unit_defines.svh"

module token_classifier_unit #(
  parameter int unsigned MAX_WORD      = 255,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // token_start, token_length, delim_char
  output logic [2:0]  m_axis_tuser,   // token_class
  output logic        m_axis_tlast
);

  localparam int unsigned Depth = 4;

  tcls_pkg::token_pair_t pair;
  tcls_pkg::token_t      mem_q [Depth];
  tcls_pkg::token_t      head;
  logic [1:0]            wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0]            cnt_q, cnt_d;
  logic                  accept, pop;
  logic [1:0]            push_n;

  assign s_axis_tready = (cnt_q <= 3'd2);
  assign accept        = s_axis_tvalid & s_axis_tready;

  tcls_scan #(
    .MAX_WORD      (MAX_WORD),
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ch_i     (s_axis_tdata),
    .eot_i    (s_axis_tlast),
    .pair_o   (pair)
  );

  always_comb begin
    push_n   = accept ? pair.cnt : 2'd0;
    pop      = m_axis_tvalid & m_axis_tready;
    wr_ptr_d = wr_ptr_q + push_n;
    rd_ptr_d = rd_ptr_q + 2'(pop);
    cnt_d    = cnt_q + 3'(push_n) - 3'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_ptr_q] <= pair.first;
    end
    if (push_n == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= pair.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign head          = mem_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = {head.delim, head.length, head.start};
  assign m_axis_tuser  = head.cls;
  assign m_axis_tlast  = head.last;

  `TCLS_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (cnt_q <= 3'(Depth)), "result queue count out of range")
  `TCLS_ASSERT(a_full_stalls, (cnt_q > 3'd2) |-> !s_axis_tready, "input taken without room for two tokens")
  `TCLS_ASSERT(a_ptr_track, (wr_ptr_q - rd_ptr_q) == cnt_q[1:0], "queue pointers disagree with count")

endmodule

>>> rtl/tcls_scan.sv
// word state registers and per-character classification, up to two tokens per beat
`include "token_classifier_unit_defines.svh"

module tcls_scan #(
  parameter int unsigned MAX_WORD      = 255,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           ch_i,
  input  logic                 eot_i,
  output tcls_pkg::token_pair_t pair_o
);

  localparam int unsigned LenW = $clog2(MAX_WORD + 1);

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] ws_q, ws_d;
  logic [LenW-1:0]          wl_q, wl_d;
  tcls_pkg::word_flags_t    fl_q, fl_d;

  logic                     dig, dot, delim, divider, oper, word_open;
  logic [LenW-1:0]          wl_inc;
  logic [POSITION_BITS-1:0] ws_upd;
  tcls_pkg::word_flags_t    fl_upd;
  tcls_pkg::token_t         word_tok, flush_tok, delim_tok;

  always_comb begin
    dig       = (ch_i >= tcls_pkg::CH_ZERO) && (ch_i <= tcls_pkg::CH_NINE);
    dot       = (ch_i == tcls_pkg::CH_DOT);
    delim     = tcls_pkg::is_delim(ch_i);
    divider   = tcls_pkg::is_divider(ch_i);
    oper      = tcls_pkg::is_operator(ch_i);
    word_open = (wl_q != '0);

    // word state after taking a word character
    fl_upd = fl_q;
    ws_upd = ws_q;
    if (!word_open) begin
      fl_upd.first_is_digit = dig;
      ws_upd                = pos_q;
    end
    fl_upd.all_digits     = fl_q.all_digits & dig;
    fl_upd.digits_or_dots = fl_q.digits_or_dots & (dig | dot);
    fl_upd.seen_dot       = fl_q.seen_dot | dot;
    fl_upd.begin_match    = fl_q.begin_match && (wl_q < LenW'(tcls_pkg::KW_BEGIN_LEN))
                            && (tcls_pkg::kw_begin_char(wl_q[2:0]) == ch_i);
    fl_upd.end_match      = fl_q.end_match && (wl_q < LenW'(tcls_pkg::KW_END_LEN))
                            && (tcls_pkg::kw_end_char(wl_q[1:0]) == ch_i);
    wl_inc = (wl_q < LenW'(MAX_WORD)) ? wl_q + LenW'(1) : wl_q;

    // word closed by a delimiter
    word_tok.cls    = tcls_pkg::word_class(fl_q, wl_q == LenW'(tcls_pkg::KW_BEGIN_LEN),
                                           wl_q == LenW'(tcls_pkg::KW_END_LEN));
    word_tok.start  = 16'(ws_q);
    word_tok.length = 8'(wl_q);
    word_tok.delim  = '0;
    word_tok.last   = 1'b0;

    // word closed by the end of text
    flush_tok.cls    = tcls_pkg::word_class(fl_upd, wl_inc == LenW'(tcls_pkg::KW_BEGIN_LEN),
                                            wl_inc == LenW'(tcls_pkg::KW_END_LEN));
    flush_tok.start  = 16'(ws_upd);
    flush_tok.length = 8'(wl_inc);
    flush_tok.delim  = '0;
    flush_tok.last   = 1'b1;

    delim_tok.cls    = divider ? tcls_pkg::CLS_DIVIDER : tcls_pkg::CLS_OPERATOR;
    delim_tok.start  = 16'(pos_q);
    delim_tok.length = 8'd1;
    delim_tok.delim  = ch_i;
    delim_tok.last   = 1'b1;

    pair_o.first  = delim_tok;
    pair_o.second = delim_tok;
    pair_o.cnt    = 2'd0;
    if (delim) begin
      if (word_open) begin
        pair_o.first      = word_tok;
        pair_o.first.last = !(divider | oper);
        pair_o.cnt        = (divider | oper) ? 2'd2 : 2'd1;
      end else begin
        pair_o.cnt = (divider | oper) ? 2'd1 : 2'd0;
      end
    end else if (eot_i) begin
      pair_o.first = flush_tok;
      pair_o.cnt   = 2'd1;
    end
  end

  always_comb begin
    pos_d = pos_q;
    ws_d  = ws_q;
    wl_d  = wl_q;
    fl_d  = fl_q;
    if (accept_i) begin
      if (eot_i) begin
        pos_d = '0;
        ws_d  = '0;
        wl_d  = '0;
        fl_d  = tcls_pkg::FLAGS_CLEAR;
      end else begin
        if (pos_q != '1) begin
          pos_d = pos_q + POSITION_BITS'(1);
        end
        if (delim) begin
          wl_d = '0;
          fl_d = tcls_pkg::FLAGS_CLEAR;
        end else begin
          wl_d = wl_inc;
          ws_d = ws_upd;
          fl_d = fl_upd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ws_q  <= '0;
      wl_q  <= '0;
      fl_q  <= tcls_pkg::FLAGS_CLEAR;
    end else begin
      pos_q <= pos_d;
      ws_q  <= ws_d;
      wl_q  <= wl_d;
      fl_q  <= fl_d;
    end
  end

  `TCLS_ASSERT(a_eot_rewinds, accept_i && eot_i |=> (pos_q == '0) && (wl_q == '0), "position not rewound after end of text")
  `TCLS_ASSERT(a_len_bound, wl_q <= LenW'(MAX_WORD), "word length beyond saturation")
  `TCLS_ASSERT(a_two_needs_word, (pair_o.cnt == 2'd2) |-> delim && word_open, "two tokens without open word")

endmodule
